@@ src/mabr_pkg.sv @@
// shared constants, types and helpers of the modbus ascii response builder
`default_nettype none

package mabr_pkg;

  // default sizes
  localparam int DEF_MEM_WORDS     = 256;
  localparam int DEF_MAX_READ_REGS = 8;

  // function codes
  localparam logic [7:0] FC_READ   = 8'h03;
  localparam logic [7:0] FC_WRITE1 = 8'h06;
  localparam logic [7:0] FC_WRITEN = 8'h10;
  localparam logic [7:0] EXC_FLAG  = 8'h80;

  // exception codes
  localparam logic [7:0] EX_BAD_FUNC = 8'h01;
  localparam logic [7:0] EX_BAD_ADDR = 8'h02;
  localparam logic [7:0] EX_BAD_QTY  = 8'h03;

  // frame characters
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  // response kinds
  localparam logic [1:0] KIND_EXC  = 2'd0;
  localparam logic [1:0] KIND_ECHO = 2'd1;
  localparam logic [1:0] KIND_READ = 2'd2;

  // character selects
  localparam logic [2:0] SEL_COLON = 3'd0;
  localparam logic [2:0] SEL_HI    = 3'd1;
  localparam logic [2:0] SEL_LO    = 3'd2;
  localparam logic [2:0] SEL_LRCH  = 3'd3;
  localparam logic [2:0] SEL_LRCL  = 3'd4;
  localparam logic [2:0] SEL_CR    = 3'd5;
  localparam logic [2:0] SEL_LF    = 3'd6;

  // controller to datapath
  typedef struct packed {
    logic       latch;
    logic       clr_step;
    logic       load;
    logic [2:0] sel;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic drop;
    logic clr_done;
    logic last_byte;
    logic next_fetch;
  } status_t;

  // uppercase hex digit of a nibble
  function automatic logic [7:0] hex_digit(input logic [3:0] v);
    logic [7:0] w;
    w = {4'h0, v & 4'h0F};
    return (v < 4'd10) ? (8'h30 + w) : (8'h37 + w);
  endfunction

endpackage

`default_nettype wire

@@ src/mabr_if.sv @@
// request and character channel interfaces
`default_nettype none

interface mabr_req_if;
  logic        valid;
  logic        ready;
  logic        frame_valid;
  logic [7:0]  slave_id;
  logic [7:0]  opcode;
  logic [15:0] reg_address;
  logic [15:0] quantity;
  logic [15:0] write_value;

  modport source (output valid, frame_valid, slave_id, opcode, reg_address, quantity,
                  write_value, input ready);
  modport sink   (input valid, frame_valid, slave_id, opcode, reg_address, quantity,
                  write_value, output ready);
endinterface

interface mabr_chr_if;
  logic       valid;
  logic       ready;
  logic [7:0] ascii_char;
  logic       last_char;

  modport source (output valid, ascii_char, last_char, input ready);
  modport sink   (input valid, ascii_char, last_char, output ready);
endinterface

`default_nettype wire

@@ src/mabr_dp.sv @@
// datapath: request decode, register memory, byte select, lrc and hex output
`default_nettype none

module mabr_dp #(
  parameter int MEM_WORDS     = 256,
  parameter int MAX_READ_REGS = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire mabr_pkg::cmd_t   cmd,
  output mabr_pkg::status_t     status,
  input  wire logic             frame_valid,
  input  wire logic [7:0]       slave_id,
  input  wire logic [7:0]       opcode,
  input  wire logic [15:0]      reg_address,
  input  wire logic [15:0]      quantity,
  input  wire logic [15:0]      write_value,
  output logic      [7:0]       ascii_char,
  output logic                  last_char
);
  import mabr_pkg::*;

  localparam int AW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
  localparam int WW = $clog2(MAX_READ_REGS + 1);
  localparam int BW = $clog2(2 * MAX_READ_REGS + 4);
  localparam logic [16:0] MEM_LIM = 17'(MEM_WORDS);
  localparam logic [15:0] QTY_MAX = 16'(MAX_READ_REGS);

  logic [15:0] mem [MEM_WORDS];
  logic [15:0] rd_data;

  logic [7:0]    slave_r, func_r, code_r, cnt_r, sum;
  logic [15:0]   addr_r, echo_r;
  logic [1:0]    kind_r;
  logic [BW-1:0] last_r, idx;
  logic [WW-1:0] word;
  logic [AW-1:0] clr;

  logic          bad_qty, bad_span, bad_wa, drop, wr_en;
  logic [1:0]    kind_next;
  logic [7:0]    code_next, cur_byte, lrc;
  logic [BW-1:0] last_next;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [15:0]   wr_data;

  // request decode
  always_comb begin
    drop      = !frame_valid || (slave_id == 8'h00);
    bad_qty   = (quantity == 16'h0000) || (quantity > QTY_MAX);
    bad_span  = ({1'b0, reg_address} + {1'b0, quantity}) > MEM_LIM;
    bad_wa    = {1'b0, reg_address} >= MEM_LIM;
    kind_next = KIND_EXC;
    code_next = EX_BAD_FUNC;
    case (opcode)
      FC_READ, FC_WRITEN: begin
        if (bad_qty) begin
          code_next = EX_BAD_QTY;
        end else if (bad_span) begin
          code_next = EX_BAD_ADDR;
        end else begin
          kind_next = (opcode == FC_READ) ? KIND_READ : KIND_ECHO;
        end
      end
      FC_WRITE1: begin
        if (bad_wa) begin
          code_next = EX_BAD_ADDR;
        end else begin
          kind_next = KIND_ECHO;
        end
      end
      default: begin
        code_next = EX_BAD_FUNC;
      end
    endcase
    case (kind_next)
      KIND_EXC:  last_next = BW'(2);
      KIND_ECHO: last_next = BW'(5);
      default:   last_next = BW'({quantity[WW-1:0], 1'b0}) + BW'(2);
    endcase
    wr_en = cmd.latch && !drop && (opcode == FC_WRITE1) && !bad_wa;
  end

  // request registers
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      slave_r <= slave_id;
      func_r  <= opcode;
      addr_r  <= reg_address;
      echo_r  <= (opcode == FC_WRITE1) ? write_value : quantity;
      cnt_r   <= {quantity[6:0], 1'b0};
      code_r  <= code_next;
      kind_r  <= kind_next;
      last_r  <= last_next;
    end
  end

  // register memory, one write and one registered read port
  always_comb begin
    wr_addr = cmd.clr_step ? clr : reg_address[AW-1:0];
    wr_data = cmd.clr_step ? 16'h0000 : write_value;
    rd_addr = AW'(addr_r + 16'(word));
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_step || wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // clearing pass counter
  always_ff @(posedge clk) begin
    if (rst) begin
      clr <= '0;
    end else if (cmd.clr_step) begin
      clr <= clr + AW'(1);
    end
  end

  // binary byte at the current index
  always_comb begin
    cur_byte = slave_r;
    case (kind_r)
      KIND_EXC: begin
        if (idx == BW'(0)) cur_byte = slave_r;
        else if (idx == BW'(1)) cur_byte = func_r | EXC_FLAG;
        else cur_byte = code_r;
      end
      KIND_ECHO: begin
        case (idx)
          BW'(0):  cur_byte = slave_r;
          BW'(1):  cur_byte = func_r;
          BW'(2):  cur_byte = addr_r[15:8];
          BW'(3):  cur_byte = addr_r[7:0];
          BW'(4):  cur_byte = echo_r[15:8];
          default: cur_byte = echo_r[7:0];
        endcase
      end
      default: begin
        if (idx == BW'(0)) cur_byte = slave_r;
        else if (idx == BW'(1)) cur_byte = func_r;
        else if (idx == BW'(2)) cur_byte = cnt_r;
        else cur_byte = idx[0] ? rd_data[15:8] : rd_data[7:0];
      end
    endcase
    lrc = 8'h00 - sum;
  end

  // byte index, word index and running sum
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      idx  <= '0;
      word <= '0;
      sum  <= 8'h00;
    end else if (cmd.load && (cmd.sel == SEL_LO)) begin
      idx <= idx + BW'(1);
      sum <= sum + cur_byte;
      if ((kind_r == KIND_READ) && (idx >= BW'(4)) && !idx[0]) begin
        word <= word + WW'(1);
      end
    end
  end

  // output character register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      case (cmd.sel)
        SEL_COLON: ascii_char <= CH_COLON;
        SEL_HI:    ascii_char <= hex_digit(cur_byte[7:4]);
        SEL_LO:    ascii_char <= hex_digit(cur_byte[3:0]);
        SEL_LRCH:  ascii_char <= hex_digit(lrc[7:4]);
        SEL_LRCL:  ascii_char <= hex_digit(lrc[3:0]);
        SEL_CR:    ascii_char <= CH_CR;
        default:   ascii_char <= CH_LF;
      endcase
      last_char <= (cmd.sel == SEL_LF);
    end
  end

  // status back to the controller
  always_comb begin
    status.drop       = drop;
    status.clr_done   = (clr == AW'(MEM_WORDS - 1));
    status.last_byte  = (idx == last_r);
    status.next_fetch = (kind_r == KIND_READ) && (idx >= BW'(2)) && !idx[0];
  end

endmodule

`default_nettype wire

@@ src/mabr_ctrl.sv @@
// controller: state machine that sequences clearing, fetches and characters
`default_nettype none

module mabr_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire mabr_pkg::status_t status,
  output mabr_pkg::cmd_t         cmd
);
  import mabr_pkg::*;

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_COLON = 4'd2;
  localparam logic [3:0] S_FETCH = 4'd3;
  localparam logic [3:0] S_HI    = 4'd4;
  localparam logic [3:0] S_LO    = 4'd5;
  localparam logic [3:0] S_LRCH  = 4'd6;
  localparam logic [3:0] S_LRCL  = 4'd7;
  localparam logic [3:0] S_CR    = 4'd8;
  localparam logic [3:0] S_LF    = 4'd9;

  logic [3:0] state, state_next;
  logic       out_valid_next, slot_free;

  // next state and commands
  always_comb begin
    state_next   = state;
    cmd.latch    = 1'b0;
    cmd.clr_step = 1'b0;
    cmd.load     = 1'b0;
    cmd.sel      = SEL_COLON;
    in_ready     = 1'b0;
    slot_free    = !out_valid || out_ready;
    case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (status.clr_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch = 1'b1;
          if (!status.drop) state_next = S_COLON;
        end
      end
      S_COLON: begin
        cmd.sel = SEL_COLON;
        if (slot_free) begin
          cmd.load   = 1'b1;
          state_next = S_HI;
        end
      end
      S_FETCH: begin
        state_next = S_HI;
      end
      S_HI: begin
        cmd.sel = SEL_HI;
        if (slot_free) begin
          cmd.load   = 1'b1;
          state_next = S_LO;
        end
      end
      S_LO: begin
        cmd.sel = SEL_LO;
        if (slot_free) begin
          cmd.load = 1'b1;
          if (status.last_byte) state_next = S_LRCH;
          else if (status.next_fetch) state_next = S_FETCH;
          else state_next = S_HI;
        end
      end
      S_LRCH: begin
        cmd.sel = SEL_LRCH;
        if (slot_free) begin
          cmd.load   = 1'b1;
          state_next = S_LRCL;
        end
      end
      S_LRCL: begin
        cmd.sel = SEL_LRCL;
        if (slot_free) begin
          cmd.load   = 1'b1;
          state_next = S_CR;
        end
      end
      S_CR: begin
        cmd.sel = SEL_CR;
        if (slot_free) begin
          cmd.load   = 1'b1;
          state_next = S_LF;
        end
      end
      S_LF: begin
        cmd.sel = SEL_LF;
        if (slot_free) begin
          cmd.load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    out_valid_next = cmd.load ? 1'b1 : (out_ready ? 1'b0 : out_valid);
  end

  // state and output valid registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

`default_nettype wire

@@ src/modbus_ascii_response_builder.sv @@
// top level of the modbus ascii response builder
//
// Takes one decoded Modbus request per beat on req and sends the ASCII
// response frame on rsp, one character per beat, last_char marking the final
// LF. Invalid and broadcast requests are taken and give nothing. Other
// requests are accepted, then sent at one character per cycle while rsp is
// ready, with a fetch state before each register word read, for the
// registered read port of the register memory: a read of n registers costs
// 4n + 11 characters; an echo takes 17 characters and an exception 11.
// The next request is taken once the final character is loaded into the
// output register. After reset the memory is cleared one word a cycle, all
// MEM_WORDS words, before the first request is accepted.
`default_nettype none

module modbus_ascii_response_builder #(
  parameter int MEM_WORDS     = mabr_pkg::DEF_MEM_WORDS,
  parameter int MAX_READ_REGS = mabr_pkg::DEF_MAX_READ_REGS
) (
  input wire logic  clk,
  input wire logic  rst,
  mabr_req_if.sink  req,
  mabr_chr_if.source rsp
);
  import mabr_pkg::*;

  cmd_t    cmd;
  status_t status;

  // sequencing
  mabr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // decode, memory and character generation
  mabr_dp #(
    .MEM_WORDS     (MEM_WORDS),
    .MAX_READ_REGS (MAX_READ_REGS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .frame_valid (req.frame_valid),
    .slave_id    (req.slave_id),
    .opcode      (req.opcode),
    .reg_address (req.reg_address),
    .quantity    (req.quantity),
    .write_value (req.write_value),
    .ascii_char  (rsp.ascii_char),
    .last_char   (rsp.last_char)
  );

endmodule

`default_nettype wire

@@ verif/modbus_ascii_response_builder_test.sv @@
// self-checking testbench of the modbus ascii response builder
`timescale 1ns / 1ps

module modbus_ascii_response_builder_test;
  import mabr_pkg::*;

  localparam int MEM_WORDS     = DEF_MEM_WORDS;
  localparam int MAX_READ_REGS = DEF_MAX_READ_REGS;
  localparam int FRAME_MAX     = 3 + 2 * MAX_READ_REGS;
  localparam int IDLE_PCT      = 29;

  typedef struct {
    logic        frame_valid;
    logic [7:0]  slave_id;
    logic [7:0]  opcode;
    logic [15:0] reg_address;
    logic [15:0] quantity;
    logic [15:0] write_value;
  } request_t;

  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } frame_char_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  mabr_req_if req_ch ();
  mabr_chr_if rsp_ch ();

  modbus_ascii_response_builder #(
    .MEM_WORDS    (MEM_WORDS),
    .MAX_READ_REGS(MAX_READ_REGS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  request_t    pending_reqs [$];
  frame_char_t expected_chars [$];
  logic [15:0] holding_regs [0:MEM_WORDS-1];
  request_t    next_req;
  frame_char_t want;
  int          idle_pct = IDLE_PCT;
  int          error_count = 0;

  // clock
  always #2 clk = ~clk;

  // uppercase ascii hex digit of a nibble
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] wide;
    wide = {4'h0, nib};
    return (nib < 4'd10) ? (8'h30 + wide) : (8'h41 + wide - 8'd10);
  endfunction

  // colon, hex byte pairs, lrc, cr and lf onto the expected characters
  function automatic void queue_frame(input logic [7:0] frame [0:FRAME_MAX-1], input int len);
    logic [7:0] sum;
    logic [7:0] lrc;
    int         i;
    sum = 8'h00;
    expected_chars.push_back({CH_COLON, 1'b0});
    for (i = 0; i < len; i++) begin
      sum = sum + frame[i];
      expected_chars.push_back({hex_char(frame[i][7:4]), 1'b0});
      expected_chars.push_back({hex_char(frame[i][3:0]), 1'b0});
    end
    lrc = 8'h00 - sum;
    expected_chars.push_back({hex_char(lrc[7:4]), 1'b0});
    expected_chars.push_back({hex_char(lrc[3:0]), 1'b0});
    expected_chars.push_back({CH_CR, 1'b0});
    expected_chars.push_back({CH_LF, 1'b1});
  endfunction

  // response of one accepted request, updating the register copy
  function automatic void predict_response(input request_t r);
    logic [7:0]  frame [0:FRAME_MAX-1];
    logic [7:0]  exc_code;
    logic [15:0] word;
    logic [16:0] span;
    logic        is_exc;
    int          len;
    int          i;
    if (!r.frame_valid || r.slave_id == 8'h00) return;
    is_exc   = 1'b0;
    exc_code = EX_BAD_FUNC;
    len      = 6;
    span     = {1'b0, r.reg_address} + {1'b0, r.quantity};
    frame[0] = r.slave_id;
    frame[1] = r.opcode;
    frame[2] = r.reg_address[15:8];
    frame[3] = r.reg_address[7:0];
    frame[4] = r.quantity[15:8];
    frame[5] = r.quantity[7:0];
    if (r.opcode == FC_READ || r.opcode == FC_WRITEN) begin
      if (r.quantity == 16'd0 || r.quantity > MAX_READ_REGS) begin
        is_exc   = 1'b1;
        exc_code = EX_BAD_QTY;
      end else if (span > MEM_WORDS) begin
        is_exc   = 1'b1;
        exc_code = EX_BAD_ADDR;
      end else if (r.opcode == FC_READ) begin
        frame[2] = {r.quantity[6:0], 1'b0};
        len = 3;
        for (i = 0; i < int'(r.quantity); i++) begin
          word = holding_regs[int'(r.reg_address) + i];
          frame[len]     = word[15:8];
          frame[len + 1] = word[7:0];
          len = len + 2;
        end
      end
    end else if (r.opcode == FC_WRITE1) begin
      if (r.reg_address >= MEM_WORDS) begin
        is_exc   = 1'b1;
        exc_code = EX_BAD_ADDR;
      end else begin
        holding_regs[int'(r.reg_address)] = r.write_value;
        frame[4] = r.write_value[15:8];
        frame[5] = r.write_value[7:0];
      end
    end else begin
      is_exc = 1'b1;
    end
    if (is_exc) begin
      frame[1] = r.opcode | EXC_FLAG;
      frame[2] = exc_code;
      len = 3;
    end
    queue_frame(frame, len);
  endfunction

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        predict_response('{req_ch.frame_valid, req_ch.slave_id, req_ch.opcode,
                           req_ch.reg_address, req_ch.quantity, req_ch.write_value});
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= idle_pct) begin
          next_req = pending_reqs.pop_front();
          req_ch.frame_valid <= next_req.frame_valid;
          req_ch.slave_id    <= next_req.slave_id;
          req_ch.opcode      <= next_req.opcode;
          req_ch.reg_address <= next_req.reg_address;
          req_ch.quantity    <= next_req.quantity;
          req_ch.write_value <= next_req.write_value;
          req_ch.valid       <= 1'b1;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // character monitor and checker
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_chars.size() == 0) begin
          error_count = error_count + 1;
          if (error_count <= 10)
            $display("unexpected char: got %h last %b", rsp_ch.ascii_char, rsp_ch.last_char);
        end else begin
          want = expected_chars.pop_front();
          if (want.code !== rsp_ch.ascii_char || want.last !== rsp_ch.last_char) begin
            error_count = error_count + 1;
            if (error_count <= 10)
              $display("char mismatch: expected %h last %b, got %h last %b",
                       want.code, want.last, rsp_ch.ascii_char, rsp_ch.last_char);
          end
        end
      end
      rsp_ch.ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  function automatic void push_request(input logic fv, input logic [7:0] slave,
                                       input logic [7:0] op, input logic [15:0] addr,
                                       input logic [15:0] qty, input logic [15:0] val);
    pending_reqs.push_back('{fv, slave, op, addr, qty, val});
  endfunction

  // mostly well-formed requests with random content, some noise
  task automatic send_random(input int count);
    request_t r;
    int       kind;
    int       n;
    for (n = 0; n < count; n++) begin
      kind          = $urandom_range(99);
      r.frame_valid = 1'b1;
      r.slave_id    = 8'($urandom_range(255, 1));
      r.write_value = 16'($urandom);
      r.quantity    = 16'($urandom_range(MAX_READ_REGS, 1));
      if ($urandom_range(99) < 60)
        r.reg_address = 16'($urandom_range(31, 0));
      else
        r.reg_address = 16'($urandom_range(MEM_WORDS - int'(r.quantity), 0));
      if (kind < 50)
        r.opcode = FC_READ;
      else if (kind < 78)
        r.opcode = FC_WRITE1;
      else if (kind < 88)
        r.opcode = FC_WRITEN;
      else
        r.opcode = 8'($urandom);
      // broken requests: wild quantity or address
      if ($urandom_range(99) < 12) begin
        if ($urandom_range(1) == 1)
          r.quantity = 16'($urandom);
        else
          r.reg_address = 16'($urandom);
      end
      // noise: dropped and broadcast frames
      if (kind % 10 == 3) begin
        r.frame_valid = 1'b0;
        r.slave_id    = 8'($urandom);
      end else if (kind % 17 == 5) begin
        r.slave_id = 8'h00;
      end
      pending_reqs.push_back(r);
    end
  endtask

  task automatic wait_drained;
    do @(negedge clk);
    while (pending_reqs.size() != 0 || req_ch.valid || expected_chars.size() != 0);
  endtask

  // stimulus and end of run
  initial begin
    int i;
    req_ch.valid       = 1'b0;
    req_ch.frame_valid = 1'b0;
    req_ch.slave_id    = 8'h00;
    req_ch.opcode      = 8'h00;
    req_ch.reg_address = 16'h0000;
    req_ch.quantity    = 16'h0000;
    req_ch.write_value = 16'h0000;
    rsp_ch.ready       = 1'b0;
    for (i = 0; i < MEM_WORDS; i++) holding_regs[i] = 16'h0000;

    // dropped and broadcast frames must not touch the registers
    push_request(1'b0, 8'h11, FC_WRITE1, 16'd9, 16'd0, 16'hDEAD);
    push_request(1'b1, 8'h00, FC_WRITE1, 16'd5, 16'd0, 16'hBEEF);
    push_request(1'b1, 8'h00, FC_READ, 16'd0, 16'd1, 16'h0000);
    // single writes at the edges of memory and beyond
    push_request(1'b1, 8'hFF, FC_WRITE1, 16'd0, 16'd0, 16'hFFFF);
    push_request(1'b1, 8'h01, FC_WRITE1, 16'd255, 16'hFFFF, 16'h0000);
    push_request(1'b1, 8'h01, FC_WRITE1, 16'd254, 16'd0, 16'hA5C3);
    push_request(1'b1, 8'h22, FC_WRITE1, 16'd256, 16'd0, 16'h0001);
    push_request(1'b1, 8'h22, FC_WRITE1, 16'hFFFF, 16'd0, 16'h0001);
    // reads: good, bad address, bad quantity
    push_request(1'b1, 8'h33, FC_READ, 16'd0, 16'd1, 16'h0000);
    push_request(1'b1, 8'h33, FC_READ, 16'd4, 16'd6, 16'h0000);
    push_request(1'b1, 8'h33, FC_READ, 16'd248, 16'(MAX_READ_REGS), 16'h0000);
    push_request(1'b1, 8'h33, FC_READ, 16'd249, 16'(MAX_READ_REGS), 16'h0000);
    push_request(1'b1, 8'h33, FC_READ, 16'd0, 16'd0, 16'h0000);
    push_request(1'b1, 8'h33, FC_READ, 16'd0, 16'(MAX_READ_REGS + 1), 16'h0000);
    push_request(1'b1, 8'h33, FC_READ, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    push_request(1'b1, 8'h33, FC_READ, 16'hFFFF, 16'd1, 16'h0000);
    // multiple write echo leaves memory alone
    push_request(1'b1, 8'h44, FC_WRITEN, 16'd0, 16'(MAX_READ_REGS), 16'h5555);
    push_request(1'b1, 8'h44, FC_WRITEN, 16'd0, 16'd0, 16'h0000);
    push_request(1'b1, 8'h44, FC_WRITEN, 16'd255, 16'd2, 16'h0000);
    push_request(1'b1, 8'h44, FC_READ, 16'd0, 16'(MAX_READ_REGS), 16'h0000);
    // unknown functions, with and without the exception bit already set
    push_request(1'b1, 8'h55, 8'h00, 16'd0, 16'd1, 16'h0000);
    push_request(1'b1, 8'h55, 8'hFF, 16'd0, 16'd1, 16'h0000);
    push_request(1'b1, 8'h55, 8'h83, 16'd0, 16'd1, 16'h0000);
    push_request(1'b1, 8'h55, 8'h04, 16'd0, 16'd1, 16'h0000);

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    send_random(50);
    // sender holds off until every response is out
    wait_drained();
    idle_pct = 0;
    send_random(46);
    wait_drained();
    idle_pct = IDLE_PCT;
    send_random(50);

    wait_drained();
    repeat (60) @(posedge clk);
    error_count = error_count + expected_chars.size();
    if (error_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

@@ sim.f @@
src/mabr_pkg.sv
src/mabr_if.sv
src/mabr_dp.sv
src/mabr_ctrl.sv
src/modbus_ascii_response_builder.sv
verif/modbus_ascii_response_builder_test.sv
